FILE: hw/rtl/edne_pkg.sv
// Shared types and widths for the exponential delta nibble encoder.
// No dependencies; imported by the encoder and by its checker.
`default_nettype none

package edne_pkg;

   localparam int SAMPLE_W = 8;
   localparam int CODE_W   = 4;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [CODE_W-1:0]          code_type;
   typedef logic [2*CODE_W-1:0]        byte_type;

endpackage

`default_nettype wire

FILE: hw/rtl/exp_delta_nibble_encoder.sv
// 4-bit exponential delta encoder: per-sample step choice, sign-guard search and packing.
// Depends on edne_pkg for the sample, code and byte types.
// A result is shown in the cycle after the edge at which its second sample leaves
// the input register.
// Throughput: one input transfer every cycle while the result register is not stalled.
// Reset: synchronous, active high; clears the predictor, held code, pair phase and table mode.
`default_nettype none

module exp_delta_nibble_encoder
   import edne_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   // Input channel.
   input  wire        req_valid,
   output logic       req_ready,
   input  sample_type req_sample,
   input  wire        req_load_seed,
   // Result channel.
   output logic       rsp_valid,
   input  wire        rsp_ready,
   output byte_type   rsp_packed_byte,
   output sample_type rsp_reconstructed,
   // Configuration: table mode.
   input  wire        csr_we,
   input  wire        csr_wdata
);

   // Step value of each code, as an 8-bit two's complement addend.
   function automatic logic [7:0] step_of(input code_type c);
      logic [7:0] s;
      case (c)
         4'd0:    s = 8'h80;
         4'd1:    s = 8'hC0;
         4'd2:    s = 8'hE0;
         4'd3:    s = 8'hF0;
         4'd4:    s = 8'hF8;
         4'd5:    s = 8'hFC;
         4'd6:    s = 8'hFE;
         4'd7:    s = 8'hFF;
         4'd8:    s = 8'h00;
         4'd9:    s = 8'h01;
         4'd10:   s = 8'h02;
         4'd11:   s = 8'h04;
         4'd12:   s = 8'h08;
         4'd13:   s = 8'h10;
         4'd14:   s = 8'h20;
         default: s = 8'h40;
      endcase
      return s;
   endfunction

   // Rounding table: the choice repeats every 256 positions, so only the
   // low byte of the difference matters.
   function automatic code_type round_code(input logic [7:0] m);
      code_type c;
      case (m) inside
         8'd0:              c = 4'd8;
         8'd1:              c = 4'd9;
         [8'd2:8'd3]:       c = 4'd10;
         [8'd4:8'd6]:       c = 4'd11;
         [8'd7:8'd12]:      c = 4'd12;
         [8'd13:8'd24]:     c = 4'd13;
         [8'd25:8'd48]:     c = 4'd14;
         [8'd49:8'd95]:     c = 4'd15;
         [8'd96:8'd160]:    c = 4'd0;
         [8'd161:8'd208]:   c = 4'd1;
         [8'd209:8'd232]:   c = 4'd2;
         [8'd233:8'd244]:   c = 4'd3;
         [8'd245:8'd250]:   c = 4'd4;
         [8'd251:8'd253]:   c = 4'd5;
         8'd254:            c = 4'd6;
         default:           c = 4'd7;
      endcase
      return c;
   endfunction

   // Truncating table, indexed by the difference offset by 256.
   function automatic code_type trunc_code(input logic [8:0] pos);
      code_type c;
      case (pos) inside
         [9'd0:9'd128]:     c = 4'd0;
         [9'd129:9'd192]:   c = 4'd1;
         [9'd193:9'd224]:   c = 4'd2;
         [9'd225:9'd240]:   c = 4'd3;
         [9'd241:9'd248]:   c = 4'd4;
         [9'd249:9'd252]:   c = 4'd5;
         [9'd253:9'd254]:   c = 4'd6;
         9'd255:            c = 4'd7;
         9'd256:            c = 4'd8;
         9'd257:            c = 4'd9;
         [9'd258:9'd259]:   c = 4'd10;
         [9'd260:9'd263]:   c = 4'd11;
         [9'd264:9'd271]:   c = 4'd12;
         [9'd272:9'd287]:   c = 4'd13;
         [9'd288:9'd319]:   c = 4'd14;
         [9'd320:9'd383]:   c = 4'd15;
         default:           c = 4'd0;
      endcase
      return c;
   endfunction

   // True when the magnitude of a signed byte is above 31.
   function automatic logic above_31(input logic [7:0] x);
      return x[7] ? (x <= 8'hE0) : (x[6:5] != 2'b00);
   endfunction

   // Absolute difference of two signed bytes.
   function automatic logic [8:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] d;
      d = {a[7], a} - {b[7], b};
      return d[8] ? (9'd0 - d) : d;
   endfunction

   // Configuration and encoder state.
   logic       mode_ff;
   logic [7:0] predictor_ff, predictor_in;
   code_type   held_ff, held_in;
   logic       phase_ff, phase_in;

   // Input register: the item waiting to be coded.
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_sample_ff;
   logic       s1_seed_ff;

   // Result register.
   logic       rsp_valid_ff, rsp_valid_in;
   byte_type   rsp_byte_ff;
   logic [7:0] rsp_rec_ff;

   logic       req_fire, s1_fire, s1_makes_rsp, out_free;

   // Coding path.
   logic [8:0] diff;
   code_type   table_c, final_c;
   logic [7:0] table_rec, final_rec;
   logic       sign_clash, need_search;

   // Search over all 16 codes as a four-level compare tree; the lower
   // code wins a tie at every node, which keeps the lowest index overall.
   logic [8:0] cand_err [16];
   logic [8:0] l1_err [8];
   code_type   l1_idx [8];
   logic [8:0] l2_err [4];
   code_type   l2_idx [4];
   logic [8:0] l3_err [2];
   code_type   l3_idx [2];
   code_type   best_c;

   always_comb begin
      diff      = {s1_sample_ff[7], s1_sample_ff} - {predictor_ff[7], predictor_ff};
      table_c   = mode_ff ? trunc_code({~diff[8], diff[7:0]}) : round_code(diff[7:0]);
      table_rec = predictor_ff + step_of(table_c);

      // The guard fires when the sign (negative, zero, positive) of the
      // reconstruction differs from the sample's and either is large.
      sign_clash  = (table_rec[7] != s1_sample_ff[7]) ||
                    ((table_rec == 8'd0) != (s1_sample_ff == 8'd0));
      need_search = sign_clash && (above_31(s1_sample_ff) || above_31(table_rec));

      for (int t = 0; t < 16; t++) begin
         cand_err[t] = abs_diff(predictor_ff + step_of(code_type'(t)), s1_sample_ff);
      end
      for (int i = 0; i < 8; i++) begin
         if (cand_err[2*i+1] < cand_err[2*i]) begin
            l1_err[i] = cand_err[2*i+1];
            l1_idx[i] = code_type'(2*i+1);
         end else begin
            l1_err[i] = cand_err[2*i];
            l1_idx[i] = code_type'(2*i);
         end
      end
      for (int i = 0; i < 4; i++) begin
         if (l1_err[2*i+1] < l1_err[2*i]) begin
            l2_err[i] = l1_err[2*i+1];
            l2_idx[i] = l1_idx[2*i+1];
         end else begin
            l2_err[i] = l1_err[2*i];
            l2_idx[i] = l1_idx[2*i];
         end
      end
      for (int i = 0; i < 2; i++) begin
         if (l2_err[2*i+1] < l2_err[2*i]) begin
            l3_err[i] = l2_err[2*i+1];
            l3_idx[i] = l2_idx[2*i+1];
         end else begin
            l3_err[i] = l2_err[2*i];
            l3_idx[i] = l2_idx[2*i];
         end
      end
      best_c = (l3_err[1] < l3_err[0]) ? l3_idx[1] : l3_idx[0];

      final_c   = need_search ? best_c : table_c;
      final_rec = predictor_ff + step_of(final_c);
   end

   // Handshake and next-state logic.
   always_comb begin
      out_free     = !rsp_valid_ff || rsp_ready;
      s1_makes_rsp = !s1_seed_ff && phase_ff;
      s1_fire      = s1_valid_ff && (!s1_makes_rsp || out_free);
      req_ready    = !s1_valid_ff || s1_fire;
      req_fire     = req_valid && req_ready;
      s1_valid_in  = req_fire || (s1_valid_ff && !s1_fire);

      predictor_in = predictor_ff;
      held_in      = held_ff;
      phase_in     = phase_ff;
      if (s1_fire) begin
         if (s1_seed_ff) begin
            // A seed drops any half-built pair and leaves the held code alone.
            predictor_in = s1_sample_ff;
            phase_in     = 1'b0;
         end else begin
            predictor_in = final_rec;
            phase_in     = !phase_ff;
            if (!phase_ff) begin
               held_in = final_c;
            end
         end
      end

      rsp_valid_in = (s1_fire && s1_makes_rsp) || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b0;
         predictor_ff <= 8'd0;
         held_ff      <= '0;
         phase_ff     <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            mode_ff <= csr_wdata;
         end
         predictor_ff <= predictor_in;
         held_ff      <= held_in;
         phase_ff     <= phase_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_sample_ff <= req_sample;
         s1_seed_ff   <= req_load_seed;
      end
      if (s1_fire && s1_makes_rsp) begin
         rsp_byte_ff <= {held_ff, final_c};
         rsp_rec_ff  <= final_rec;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_packed_byte   = rsp_byte_ff;
   assign rsp_reconstructed = sample_type'(rsp_rec_ff);

endmodule

`default_nettype wire

FILE: hw/rtl/edne_checker.sv
// Port-level checker for the exponential delta nibble encoder, with its bind.
// Depends on edne_pkg for the sample and byte types.
`default_nettype none

module edne_checker
   import edne_pkg::*;
(
   input wire        clock,
   input wire        reset,
   input wire        req_valid,
   input wire        req_ready,
   input wire        req_load_seed,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input byte_type   rsp_packed_byte,
   input sample_type rsp_reconstructed
);

   // A stalled result keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_packed_byte)
         && $stable(rsp_reconstructed))
      else $error("stalled result changed");

   // With no result pending the encoder always takes a new sample.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled while the result register was empty");

   // Reset leaves no result pending.
   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result pending right after reset");

   // A seed transfer never produces a result of its own.
   a_seed_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_load_seed |=> ##1 !$rose(rsp_valid))
      else $error("seed transfer produced a result");

endmodule

bind exp_delta_nibble_encoder edne_checker u_edne_checker (.*);

`default_nettype wire

FILE: dv/tb_exp_delta_nibble_encoder.sv
// Self-checking testbench for exp_delta_nibble_encoder: directed and random sample streams,
// both step tables, with idle and stall phases on both channels.
// Depends on edne_pkg and the encoder RTL only.
`timescale 1ns / 1ps

module tb_exp_delta_nibble_encoder
   import edne_pkg::*;
();

   // The run is cut off here.
   localparam int CYCLE_LIMIT  = 200000;
   // Cycles allowed for an item still inside the block when no result is owed for it.
   localparam int DRAIN_CYCLES = 8;
   localparam int DRAIN_GUARD  = 5000;

   localparam bit MODE_ROUNDING   = 1'b0;
   localparam bit MODE_TRUNCATING = 1'b1;

   typedef struct packed {
      byte_type   packed_byte;
      sample_type reconstructed;
   } encoded_pair_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   sample_type req_sample = '0;
   logic       req_load_seed = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   byte_type   rsp_packed_byte;
   sample_type rsp_reconstructed;
   logic       csr_we = 1'b0;
   logic       csr_wdata = 1'b0;

   // Our own copy of the encoder state, advanced once per accepted input transfer.
   sample_type enc_pred  = '0;
   code_type   enc_held  = '0;
   bit         enc_phase = 1'b0;
   bit         enc_mode  = MODE_ROUNDING;

   // Packed bytes that the block still owes us, oldest first.
   encoded_pair_type pending_pairs [$];
   encoded_pair_type want_pair;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int error_count   = 0;
   int cycle_count   = 0;
   int last_sample   = 0;

   exp_delta_nibble_encoder dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_sample        (req_sample),
      .req_load_seed     (req_load_seed),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_packed_byte   (rsp_packed_byte),
      .rsp_reconstructed (rsp_reconstructed),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Encoder arithmetic, kept independent of the RTL.
   // ---------------------------------------------------------------------------------------

   // Code c stands for a step of 0 at code 8, growing powers of two above it and
   // negative powers of two below it, down to -128 at code 0.
   function automatic int step_value(code_type c);
      case (c)
         4'd0:    return -128;
         4'd1:    return -64;
         4'd2:    return -32;
         4'd3:    return -16;
         4'd4:    return -8;
         4'd5:    return -4;
         4'd6:    return -2;
         4'd7:    return -1;
         4'd8:    return 0;
         4'd9:    return 1;
         4'd10:   return 2;
         4'd11:   return 4;
         4'd12:   return 8;
         4'd13:   return 16;
         4'd14:   return 32;
         default: return 64;
      endcase
   endfunction

   // The predictor adds the step and wraps to 8 bits.
   function automatic sample_type add_step(sample_type base, code_type c);
      return base + sample_type'(step_value(c));
   endfunction

   // Width of each run of equal codes over the difference range, offset by 256.
   // The rounding table repeats its sixteen runs twice, which gives the modulo 256 behavior.
   function automatic int run_width(bit mode, int idx);
      if (mode == MODE_TRUNCATING) begin
         case (idx)
            0:       return 129;
            1:       return 64;
            2:       return 32;
            3:       return 16;
            4:       return 8;
            5:       return 4;
            6:       return 2;
            7, 8, 9: return 1;
            10:      return 2;
            11:      return 4;
            12:      return 8;
            13:      return 16;
            14:      return 32;
            15:      return 64;
            default: return 128;
         endcase
      end
      case (idx % 16)
         0, 1, 14, 15: return 1;
         2:            return 2;
         3, 13:        return 3;
         4, 12:        return 6;
         5, 11:        return 12;
         6, 10:        return 24;
         7:            return 47;
         8:            return 65;
         default:      return 48;
      endcase
   endfunction

   function automatic code_type table_lookup(int diff, bit mode);
      int       pos;
      int       acc;
      int       runs;
      code_type c;
      pos  = diff + 256;
      acc  = 0;
      runs = (mode == MODE_TRUNCATING) ? 17 : 32;
      c    = (mode == MODE_TRUNCATING) ? 4'd0 : 4'd8;
      for (int i = 0; i < runs; i++) begin
         acc += run_width(mode, i);
         if (pos < acc)
            return c;
         c = code_type'(c + 1);
      end
      return c;
   endfunction

   function automatic int sign3(int v);
      return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
   endfunction

   function automatic int magnitude(int v);
      return (v < 0) ? -v : v;
   endfunction

   // Exhaustive search over all sixteen codes; a tie keeps the lower code.
   function automatic code_type closest_code(sample_type base, sample_type target);
      int       best;
      int       err;
      code_type id;
      best = 289;
      id   = '0;
      for (int t = 0; t < 16; t++) begin
         err = magnitude(int'(add_step(base, code_type'(t))) - int'(target));
         if (err < best) begin
            best = err;
            id   = code_type'(t);
         end
      end
      return id;
   endfunction

   // Advances the state copy by one accepted item and queues the byte it completes.
   task automatic encode_sample(sample_type s, bit seed);
      code_type   c;
      sample_type rec;
      if (seed) begin
         // A seed drops any half-built pair but leaves the held code alone.
         enc_pred  = s;
         enc_phase = 1'b0;
         return;
      end
      c   = table_lookup(int'(s) - int'(enc_pred), enc_mode);
      rec = add_step(enc_pred, c);
      // Sign guard: a reconstruction on the wrong side of zero is only tolerated near zero.
      if (sign3(int'(rec)) != sign3(int'(s))
          && (magnitude(int'(s)) > 31 || magnitude(int'(rec)) > 31)) begin
         c   = closest_code(enc_pred, s);
         rec = add_step(enc_pred, c);
      end
      enc_pred = rec;
      if (!enc_phase) begin
         enc_held  = c;
         enc_phase = 1'b1;
      end else begin
         enc_phase = 1'b0;
         pending_pairs.push_back('{packed_byte: {enc_held, c}, reconstructed: rec});
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // Channel handling.
   // ---------------------------------------------------------------------------------------

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
      error_count++;
   endtask

   // Every result transfer is checked against the oldest owed byte. The ready for the next
   // cycle is drawn at the same edge, so stalls land on every phase of the block's work.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pairs.size() == 0) begin
            report_mismatch("unexpected result, packed_byte", int'(rsp_packed_byte), -1);
         end else begin
            want_pair = pending_pairs.pop_front();
            if (rsp_packed_byte !== want_pair.packed_byte)
               report_mismatch("packed_byte", int'(rsp_packed_byte),
                               int'(want_pair.packed_byte));
            if (rsp_reconstructed !== want_pair.reconstructed)
               report_mismatch("reconstructed", int'(rsp_reconstructed),
                               int'(want_pair.reconstructed));
         end
      end
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Sends one item. It is called at a rising edge; an idle gap may come first, and valid
   // then stays high with a fixed payload until the transfer happens. When the next item
   // follows with no gap, valid is simply left high.
   task automatic send_item(sample_type s, bit seed);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_sample    <= s;
      req_load_seed <= seed;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      encode_sample(s, seed);
   endtask

   // Waits until every owed byte has arrived, then lets any item that owes nothing leave
   // the block. A byte still missing after the guard counts as a failure.
   task automatic wait_drained();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (pending_pairs.size() != 0 && waited < DRAIN_GUARD) begin
         @(posedge clock);
         waited++;
      end
      if (pending_pairs.size() != 0) begin
         report_mismatch("results never delivered", 0, pending_pairs.size());
         pending_pairs.delete();
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // The table mode only changes while the block is empty.
   task automatic write_table_mode(bit mode);
      wait_drained();
      csr_we    <= 1'b1;
      csr_wdata <= mode;
      @(posedge clock);
      csr_we   <= 1'b0;
      enc_mode  = mode;
   endtask

   // ---------------------------------------------------------------------------------------
   // Tests.
   // ---------------------------------------------------------------------------------------

   // Pairing straight out of reset, a seed that drops a half-built pair, and a lone seed.
   task automatic test_seed_and_pairing();
      send_idle_pct = 10;
      rsp_stall_pct = 10;
      send_item(8'sd0, 1'b0);
      send_item(8'sd127, 1'b0);
      send_item(8'sd5, 1'b0);
      send_item(8'sd0, 1'b1);
      send_item(8'sd1, 1'b0);
      send_item(-8'sd1, 1'b0);
      send_item(-8'sd128, 1'b1);
   endtask

   // Full-scale swings across zero exercise the sign guard; the values around 31 sit
   // right at the edge of the magnitude condition of the sign guard.
   task automatic test_sign_guard_search();
      send_item(8'sd127, 1'b1);
      send_item(-8'sd128, 1'b0);
      send_item(-8'sd128, 1'b0);
      send_item(-8'sd128, 1'b1);
      send_item(8'sd127, 1'b0);
      send_item(8'sd0, 1'b0);
      send_item(8'sd32, 1'b1);
      send_item(-8'sd32, 1'b0);
      send_item(8'sd31, 1'b0);
      send_item(-8'sd31, 1'b0);
   endtask

   // Truncating table at the largest differences, where the step wraps modulo 256.
   task automatic test_truncating_wrap();
      write_table_mode(MODE_TRUNCATING);
      send_item(-8'sd128, 1'b1);
      send_item(8'sd127, 1'b0);
      send_item(-8'sd128, 1'b0);
      send_item(8'sd0, 1'b1);
      send_item(-8'sd128, 1'b0);
      send_item(8'sd127, 1'b0);
      send_item(8'sd0, 1'b0);
   endtask

   // Mostly audio-like streams that drift from the last sample, with fully random samples
   // and occasional seeds mixed in so that pairs get broken now and then.
   task automatic test_random_stream(bit mode, int count, int idle_pct, int stall_pct);
      int roll;
      int v;
      write_table_mode(mode);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(99);
         if (roll < 6) begin
            v = $urandom_range(255) - 128;
            send_item(sample_type'(v), 1'b1);
         end else begin
            if (roll < 40)
               v = $urandom_range(255) - 128;
            else if (roll < 75)
               v = last_sample + $urandom_range(16) - 8;
            else
               v = last_sample + $urandom_range(96) - 48;
            if (v > 127)
               v = 127;
            if (v < -128)
               v = -128;
            send_item(sample_type'(v), 1'b0);
         end
         last_sample = v;
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_seed_and_pairing();
      test_sign_guard_search();
      test_truncating_wrap();

      test_random_stream(MODE_ROUNDING,   175, 0,  0);
      test_random_stream(MODE_TRUNCATING, 175, 66, 0);
      test_random_stream(MODE_ROUNDING,   175, 0,  66);
      test_random_stream(MODE_TRUNCATING, 175, 10, 10);

      wait_drained();
      if (error_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/edne_pkg.sv
hw/rtl/exp_delta_nibble_encoder.sv
hw/rtl/edne_checker.sv
dv/tb_exp_delta_nibble_encoder.sv
